// File: hw/rtl/dht_pkg.sv
// shared types and constants for the double hash table engine
// no dependencies
`timescale 1ns / 1ps
package dht_pkg;
    localparam int DEPTH        = 64;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_BITS     = $clog2(DEPTH);
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int HASH_BITS    = 32;
    // hashes are reduced four bits a cycle
    localparam int NIB_STEPS    = HASH_BITS / 4;
    localparam int NIB_BITS     = $clog2(NIB_STEPS);

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [2:0] K_INSERT = 3'd0;
    localparam logic [2:0] K_LOOKUP = 3'd1;
    localparam logic [2:0] K_REMOVE = 3'd2;
    localparam logic [2:0] K_CLEAR  = 3'd3;
    localparam logic [2:0] K_SEEK   = 3'd4;

    localparam logic [2:0] RS_OK       = 3'd0;
    localparam logic [2:0] RS_FULL     = 3'd1;
    localparam logic [2:0] RS_EXISTS   = 3'd2;
    localparam logic [2:0] RS_NOTFOUND = 3'd3;
    localparam logic [2:0] RS_NOFREE   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, set probe to start
        logic mod_step;   // reduce four more hash bits mod size
        logic step;       // advance probe index
        logic rd;         // issue slot read at current probe
        logic wr_live;    // write key/payload, mark live
        logic wr_tomb;    // mark tombstone
        logic clr_step;   // clear one status entry
        logic emit;       // drive the result strobe
        logic [2:0] st;   // status to report
        logic has_slot;   // report slot contents
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] sts;      // status of slot read
        logic key_eq;         // key of slot read matches
        logic last;           // probe index is last one
        logic full;           // live count at capacity
        logic seek_oob;       // seek start past size
        logic clr_done;       // clear sweep finished
        logic mod_done;       // last hash reduction step
        logic [2:0] kind;
    } t_stat;
endpackage

// File: hw/rtl/dht_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hw/rtl/dht_datapath.sv
// probe arithmetic, slot storage and result register
// depends on dht_pkg and dht_ram
`timescale 1ns / 1ps
module dht_datapath import dht_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CNT_BITS-1:0]     i_cfg_data,
    input  logic [2:0]              i_kind,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [HASH_BITS-1:0]    i_hash_one,
    input  logic [HASH_BITS-1:0]    i_hash_two,
    input  logic [IDX_BITS-1:0]     i_start_index,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [KEY_BITS-1:0]     o_found_key,
    output logic [PAYLOAD_BITS-1:0] o_found_payload,
    output logic [IDX_BITS-1:0]     o_slot_index,
    output logic [CNT_BITS-1:0]     o_entry_count
);
    logic [CNT_BITS-1:0]     r_size;
    logic [CNT_BITS-1:0]     r_count;
    logic [2:0]              r_kind;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [HASH_BITS-1:0]    r_h1;      // hash bits still to reduce
    logic [HASH_BITS-1:0]    r_h2;
    logic [NIB_BITS-1:0]     r_mcnt;
    logic [IDX_BITS-1:0]     r_pos;     // current slot
    logic [IDX_BITS-1:0]     r_stride;  // step mod size
    logic [CNT_BITS-1:0]     r_i;       // probe number or seek index
    logic [IDX_BITS-1:0]     r_hit;     // slot last read
    logic [IDX_BITS-1:0]     r_clr;
    logic [1:0]              sts_rd;
    logic                    sts_we;
    logic [IDX_BITS-1:0]     sts_addr;
    logic [1:0]              sts_wdata;
    logic [CNT_BITS-1:0]     n_eff;
    logic [IDX_BITS:0]       sum;
    logic [KEY_BITS-1:0]     key_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic                    seek;

    // shift four bits into a remainder below n
    function automatic logic [IDX_BITS-1:0] mod_nib(logic [IDX_BITS-1:0] rem,
            logic [3:0] nib, logic [CNT_BITS-1:0] n);
        logic [CNT_BITS:0]   t;
        logic [IDX_BITS-1:0] r;
        r = rem;
        for (int b = 3; b >= 0; b--) begin
            t = {1'b0, r, nib[b]};
            if (t >= {1'b0, n}) t = t - {1'b0, n};
            r = t[IDX_BITS-1:0];
        end
        return r;
    endfunction

    assign n_eff = (r_size == '0) ? CNT_BITS'(1) :
                   (r_size > CNT_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : r_size;
    assign seek   = (r_kind == K_SEEK);
    assign sum    = {1'b0, r_pos} + {1'b0, r_stride};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CNT_BITS'(DEPTH);
            r_count <= '0;
            r_clr <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_data;
            o_valid <= i_cmd.emit;
            if (i_cmd.wr_live) r_count <= r_count + CNT_BITS'(1);
            if (i_cmd.wr_tomb && r_count != '0) r_count <= r_count - CNT_BITS'(1);
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + IDX_BITS'(1);
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key <= i_key;
            r_pay <= i_payload;
            r_h1 <= i_hash_one;
            r_h2 <= i_hash_two | HASH_BITS'(1);
            r_mcnt <= '0;
            r_i <= (i_kind == K_SEEK) ? CNT_BITS'(i_start_index) : '0;
            r_pos <= (i_kind == K_SEEK) ? i_start_index : '0;
            r_stride <= '0;
        end else if (i_cmd.mod_step) begin
            r_h1 <= {r_h1[HASH_BITS-5:0], 4'd0};
            r_h2 <= {r_h2[HASH_BITS-5:0], 4'd0};
            r_mcnt <= r_mcnt + NIB_BITS'(1);
            r_pos <= mod_nib(r_pos, r_h1[HASH_BITS-1 -: 4], n_eff);
            r_stride <= mod_nib(r_stride, r_h2[HASH_BITS-1 -: 4], n_eff);
        end else if (i_cmd.step) begin
            r_i <= r_i + CNT_BITS'(1);
            if (seek) r_pos <= r_pos + IDX_BITS'(1);
            else r_pos <= (sum >= {1'b0, n_eff}) ?
                IDX_BITS'(sum - {1'b0, n_eff}) : sum[IDX_BITS-1:0];
        end
        if (i_cmd.rd) r_hit <= r_pos;
        if (i_cmd.emit) begin
            o_status <= i_cmd.st;
            o_found_key <= i_cmd.has_slot ? (i_cmd.wr_live ? r_key : key_rd) : '0;
            o_found_payload <= i_cmd.has_slot ? (i_cmd.wr_live ? r_pay : pay_rd) : '0;
            o_slot_index <= i_cmd.has_slot ? r_hit : '0;
            o_entry_count <= i_cmd.wr_live ? r_count + CNT_BITS'(1) :
                (i_cmd.wr_tomb && r_count != '0) ? r_count - CNT_BITS'(1) :
                i_cmd.clr_step ? '0 : r_count;
        end
    end

    // status entries: one write or one read a cycle
    assign sts_we    = i_cmd.clr_step | i_cmd.wr_live | i_cmd.wr_tomb;
    assign sts_addr  = i_cmd.clr_step ? r_clr :
                       (i_cmd.wr_live | i_cmd.wr_tomb) ? r_hit : r_pos;
    assign sts_wdata = i_cmd.clr_step ? ST_EMPTY : i_cmd.wr_live ? ST_LIVE : ST_TOMB;

    dht_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_sts (
        .i_clk(i_clk), .i_we(sts_we), .i_addr(sts_addr),
        .i_wdata(sts_wdata), .o_rdata(sts_rd));
    dht_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key (
        .i_clk(i_clk), .i_we(i_cmd.wr_live), .i_addr(i_cmd.wr_live ? r_hit : r_pos),
        .i_wdata(r_key), .o_rdata(key_rd));
    dht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_pay (
        .i_clk(i_clk), .i_we(i_cmd.wr_live), .i_addr(i_cmd.wr_live ? r_hit : r_pos),
        .i_wdata(r_pay), .o_rdata(pay_rd));

    always_comb begin
        o_stat.sts = sts_rd;
        o_stat.key_eq = (key_rd == r_key);
        o_stat.last = (r_i + CNT_BITS'(1) >= n_eff);
        o_stat.full = (r_count >= n_eff);
        o_stat.seek_oob = (r_i >= n_eff);
        o_stat.clr_done = (r_clr == IDX_BITS'(DEPTH - 1));
        o_stat.mod_done = (r_mcnt == NIB_BITS'(NIB_STEPS - 1));
        o_stat.kind = r_kind;
    end
endmodule

// File: hw/rtl/dht_ctrl.sv
// sequencer for insert, lookup, remove, clear and seek
// depends on dht_pkg
`timescale 1ns / 1ps
module dht_ctrl import dht_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_HASH, S_DISP, S_READ, S_EVAL, S_CLEAR, S_WRITE
    } t_state;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else r_state <= n_state;
    end
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            // sweep after reset empties every slot
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: if (i_start) begin
                o_cmd.load = 1'b1;
                n_state = S_HASH;
            end
            S_HASH: begin
                case (i_stat.kind)
                    K_INSERT, K_LOOKUP, K_REMOVE: begin
                        o_cmd.mod_step = 1'b1;
                        if (i_stat.mod_done) n_state = S_DISP;
                    end
                    default: n_state = S_DISP;
                endcase
            end
            S_DISP: begin
                case (i_stat.kind)
                    K_INSERT: if (i_stat.full) begin
                        o_cmd.emit = 1'b1; o_cmd.st = RS_FULL; n_state = S_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1; n_state = S_READ;
                    end
                    K_LOOKUP, K_REMOVE: begin
                        o_cmd.rd = 1'b1; n_state = S_READ;
                    end
                    K_CLEAR: n_state = S_CLEAR;
                    K_SEEK: if (i_stat.seek_oob) begin
                        o_cmd.emit = 1'b1; o_cmd.st = RS_NOTFOUND; n_state = S_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1; n_state = S_READ;
                    end
                    default: begin
                        o_cmd.emit = 1'b1; o_cmd.st = RS_NOTFOUND; n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: n_state = S_EVAL;   // ram and status read latency
            S_EVAL: begin
                case (i_stat.kind)
                    K_INSERT: begin
                        if (i_stat.sts != ST_LIVE) begin
                            n_state = S_WRITE;
                        end else if (i_stat.key_eq) begin
                            o_cmd.emit = 1'b1; o_cmd.st = RS_EXISTS;
                            o_cmd.has_slot = 1'b1; n_state = S_IDLE;
                        end else if (i_stat.last) begin
                            o_cmd.emit = 1'b1; o_cmd.st = RS_NOFREE; n_state = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1; n_state = S_DISP;
                        end
                    end
                    K_SEEK: begin
                        if (i_stat.sts == ST_LIVE) begin
                            o_cmd.emit = 1'b1; o_cmd.st = RS_OK;
                            o_cmd.has_slot = 1'b1; n_state = S_IDLE;
                        end else if (i_stat.last) begin
                            o_cmd.emit = 1'b1; o_cmd.st = RS_NOTFOUND; n_state = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1; n_state = S_DISP;
                        end
                    end
                    default: begin
                        if (i_stat.sts == ST_LIVE && i_stat.key_eq) begin
                            o_cmd.emit = 1'b1; o_cmd.st = RS_OK; o_cmd.has_slot = 1'b1;
                            o_cmd.wr_tomb = (i_stat.kind == K_REMOVE);
                            n_state = S_IDLE;
                        end else if (i_stat.sts == ST_EMPTY || i_stat.last) begin
                            o_cmd.emit = 1'b1; o_cmd.st = RS_NOTFOUND; n_state = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1; n_state = S_DISP;
                        end
                    end
                endcase
            end
            S_WRITE: begin
                o_cmd.wr_live = 1'b1; o_cmd.emit = 1'b1; o_cmd.st = RS_OK;
                o_cmd.has_slot = 1'b1; n_state = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    o_cmd.emit = 1'b1; o_cmd.st = RS_OK; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/double_hash_table_engine_unit.sv
// double hash table engine top level: controller plus datapath
// depends on dht_pkg, dht_ctrl, dht_datapath
//
// usage: raise start with a request while busy is low; the request is
// taken at that edge and busy rises. one result per request appears for a
// single cycle with o_valid high; the receiver cannot stall it. busy is
// already low in that cycle, so the next request can be taken at its end.
// request flow from the accepting edge to the result strobe:
// insert, lookup and remove first reduce both hashes mod the size, four
// bits a cycle, then pass dispatch, slot read and evaluate states for each
// probe, bounded by the single ported slot memories; an insert that writes
// adds a write state. a full table is reported from dispatch, before any
// slot read. seek skips the reduction and probes slots in order; a start
// past the size is reported from dispatch, as are unknown kinds. clear
// sweeps all 64 status entries, one a cycle.
// i_cfg_we writes the slot count in use (0 acts as 1, above 64 acts as 64);
// write it only while idle. reset zeroes the count and sets the size to 64,
// then a sweep with busy high empties every slot.
`timescale 1ns / 1ps
module double_hash_table_engine_unit import dht_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [CNT_BITS-1:0]     i_cfg_data,
    input  logic [2:0]              i_kind,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [HASH_BITS-1:0]    i_hash_one,
    input  logic [HASH_BITS-1:0]    i_hash_two,
    input  logic [IDX_BITS-1:0]     i_start_index,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [KEY_BITS-1:0]     o_found_key,
    output logic [PAYLOAD_BITS-1:0] o_found_payload,
    output logic [IDX_BITS-1:0]     o_slot_index,
    output logic [CNT_BITS-1:0]     o_entry_count
);
    t_cmd  cmd;
    t_stat stat;

    dht_ctrl u_ctrl (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_stat(stat), .o_busy(busy), .o_cmd(cmd));

    dht_datapath u_dp (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_kind(i_kind), .i_key(i_key),
        .i_payload(i_payload), .i_hash_one(i_hash_one), .i_hash_two(i_hash_two),
        .i_start_index(i_start_index), .i_cmd(cmd), .o_stat(stat),
        .o_valid(o_valid), .o_status(o_status), .o_found_key(o_found_key),
        .o_found_payload(o_found_payload), .o_slot_index(o_slot_index),
        .o_entry_count(o_entry_count));

    // a result transfer always ends a busy period
    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while still busy");
    // the live count never passes the table depth
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= CNT_BITS'(DEPTH)) else $error("count overflow");
    // an accepted request raises busy in the next cycle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
endmodule
